>>> src/gfp_pkg.sv
// gfp_pkg: shared constants and types for the gyro frame parser.
// No dependencies; imported by gfp_assembler and gyro_frame_parser.
package gfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'h5A;
  localparam logic [7:0] TYPE_RATE   = 8'hAA;
  localparam logic [7:0] TYPE_YAW    = 8'hBB;
  localparam logic [7:0] TYPE_STATUS = 8'hCC;
  localparam logic [7:0] BIAS_GOOD   = 8'h96;

  // byte position within a frame
  localparam logic [2:0] CNT_HUNT  = 3'd0;
  localparam logic [2:0] CNT_TYPE  = 3'd1;
  localparam logic [2:0] CNT_LOW   = 3'd2;
  localparam logic [2:0] CNT_HIGH  = 3'd3;
  localparam logic [2:0] CNT_CHECK = 3'd4;

  localparam logic [1:0] KIND_RATE   = 2'd0;
  localparam logic [1:0] KIND_YAW    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [1:0]         frame_kind;
    logic signed [15:0] data_word;
    logic               bias_ok;
  } result_t;

endpackage

>>> src/gyro_frame_parser.sv
// gyro_frame_parser: top level; byte input channel, frame assembler and
// registered result channel. Depends on gfp_pkg and gfp_assembler.
// A result is registered at the output in the cycle after its checksum byte
// is accepted. Throughput: one byte per cycle; the output register frees in
// the same cycle it is taken, so input stalls only while a result waits.
// Reset (rst, synchronous) returns the parser to header hunt and empties
// the output register.
module gyro_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_kind,
  output logic signed [15:0] data_word,
  output logic               bias_ok
);
  import gfp_pkg::*;

  result_t res;
  logic    take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  gfp_assembler u_asm (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= take && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      frame_kind <= res.frame_kind;
      data_word  <= res.data_word;
      bias_ok    <= res.bias_ok;
    end
  end

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_kind != 2'd3) else $error("illegal frame kind");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == KIND_STATUS |-> data_word == 16'sd0)
    else $error("status frame carries nonzero value");

  a_bias_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_STATUS |-> !bias_ok)
    else $error("bias flag on data frame");

endmodule

>>> src/gfp_assembler.sv
// gfp_assembler: frame state tracker; decodes one byte per accepted item
// and presents the resulting frame, if any, combinationally. Uses gfp_pkg.
module gfp_assembler (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output gfp_pkg::result_t  res
);
  import gfp_pkg::*;

  logic [2:0] count, count_next;
  logic [7:0] frame_type, frame_type_next;
  logic [7:0] data_low, data_low_next;
  logic [7:0] data_high, data_high_next;
  logic [7:0] running_sum, running_sum_next;
  logic       sum_match;

  assign sum_match = (rx_byte == running_sum);

  always_comb begin
    count_next       = count;
    frame_type_next  = frame_type;
    data_low_next    = data_low;
    data_high_next   = data_high;
    running_sum_next = running_sum;
    res              = '0;
    case (count)
      CNT_TYPE: begin
        if (rx_byte inside {TYPE_RATE, TYPE_YAW, TYPE_STATUS}) begin
          frame_type_next  = rx_byte;
          running_sum_next = running_sum + rx_byte;
          count_next       = CNT_LOW;
        end else begin
          running_sum_next = HDR_BYTE;
          count_next       = (rx_byte == HDR_BYTE) ? CNT_TYPE : CNT_HUNT;
        end
      end
      CNT_LOW: begin
        data_low_next    = rx_byte;
        running_sum_next = running_sum + rx_byte;
        count_next       = CNT_HIGH;
      end
      CNT_HIGH: begin
        data_high_next   = rx_byte;
        running_sum_next = running_sum + rx_byte;
        count_next       = CNT_CHECK;
      end
      CNT_CHECK: begin
        count_next = CNT_HUNT;
        if (frame_type == TYPE_STATUS) begin
          res.valid      = 1'b1;
          res.frame_kind = KIND_STATUS;
          res.bias_ok    = (data_low == 8'd0) && (data_high == 8'd0) &&
                           ((rx_byte == BIAS_GOOD) || sum_match);
        end else if (sum_match) begin
          res.valid      = 1'b1;
          res.frame_kind = (frame_type == TYPE_YAW) ? KIND_YAW : KIND_RATE;
          res.data_word  = {data_high, data_low};
        end
      end
      default: begin
        running_sum_next = HDR_BYTE;
        count_next       = (rx_byte == HDR_BYTE) ? CNT_TYPE : CNT_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_HUNT;
    end else if (take) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_type  <= frame_type_next;
      data_low    <= data_low_next;
      data_high   <= data_high_next;
      running_sum <= running_sum_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_CHECK) else $error("frame byte count out of range");

  a_check_wraps: assert property (@(posedge clk) disable iff (rst)
    take && count == CNT_CHECK |=> count == CNT_HUNT)
    else $error("count did not return to hunt after checksum byte");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> count == CNT_CHECK)
    else $error("result raised before last frame byte");

endmodule
